>>> sv/sorted_priority_table_assert.svh
// assertion macros for the sorted priority table
// no dependencies; taken in by the modules that check their own logic
`ifndef SORTED_PRIORITY_TABLE_ASSERT_SVH
`define SORTED_PRIORITY_TABLE_ASSERT_SVH

// same-cycle implication
`define SPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/spt_pkg.sv
// shared types and constants of the sorted priority table
// no dependencies
`default_nettype none
package spt_pkg;
    localparam int KEY_BITS        = 8;
    localparam int LEVEL_BITS      = 8;
    localparam int REQ_BITS        = 16;
    localparam int COUNT_BITS      = 5;
    localparam int DEPTH_DEF       = 16;
    localparam int PRIO_BITS_DEF   = 16;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_SET_PRIO  = 3'd2,
        OP_TO_TOP    = 3'd3,
        OP_PRESET    = 3'd4,
        OP_AIMED     = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_UNUSED    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_INSERT = 2'd2
    } t_mode;

    typedef struct packed {
        logic                loc;
        t_mode               mode;
        logic                any;
        logic [KEY_BITS-1:0] key;
    } t_cell_ctrl;
endpackage
`default_nettype wire

>>> sv/spt_if.sv
// input and result channels of the sorted priority table
// depends on spt_pkg
`default_nettype none
interface spt_in_if;
    import spt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [2:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [REQ_BITS-1:0]   priority_req;
    logic [LEVEL_BITS-1:0] level;
    logic                  target_present;
    modport source (output valid, operation, key, priority_req, level, target_present,
                    input ready);
    modport sink   (input valid, operation, key, priority_req, level, target_present,
                    output ready);
endinterface

interface spt_out_if;
    import spt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic                  head_present;
    logic [KEY_BITS-1:0]   head_key;
    logic [REQ_BITS-1:0]   head_priority;
    logic [COUNT_BITS-1:0] entry_count;
    logic [REQ_BITS-1:0]   key_priority;
    logic                  aimed_present;
    logic [KEY_BITS-1:0]   aimed_key;
    logic                  preset_present;
    logic [KEY_BITS-1:0]   preset_key;
    logic                  fight_ended;
    modport source (output valid, ok, head_present, head_key, head_priority, entry_count,
                    key_priority, aimed_present, aimed_key, preset_present, preset_key,
                    fight_ended, input ready);
    modport sink   (input valid, ok, head_present, head_key, head_priority, entry_count,
                    key_priority, aimed_present, aimed_key, preset_present, preset_key,
                    fight_ended, output ready);
endinterface
`default_nettype wire

>>> sv/sorted_priority_table.sv
// top level of the sorted priority table: control, targets, config port
// depends on spt_pkg, spt_if, spt_cell and sorted_priority_table_assert.svh
//
// usage
//   i_in carries one operation per beat (add, remove, set priority, move to
//   top, set preset or aimed target, clear); o_out returns one result beat
//   for each, with the head, count, the key's priority and both targets after
//   the operation. own_level is written over the apb port at byte address 0;
//   the user must write it only while idle, which the block does not enforce.
// timing
//   the table is a row of slot cells. a beat is taken in ST_IDLE, the
//   cells compare the key in ST_LOC, then all cells shift in parallel in
//   ST_UPD, then ST_OUT registers the result. one beat is in work at a time.
//   the result register lets the next beat be taken while a result waits;
//   a stalled receiver holds the block before its result stage.
// reset
//   synchronous active-low reset empties the table, clears both targets
//   and own_level; slot contents are not cleared.
`default_nettype none
module sorted_priority_table #(
    parameter int TABLE_DEPTH   = spt_pkg::DEPTH_DEF,
    parameter int PRIORITY_BITS = spt_pkg::PRIO_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    spt_in_if.sink                     i_in,
    spt_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spt_pkg::APB_AW-1:0] paddr,
    input  logic [spt_pkg::APB_DW-1:0] pwdata,
    output logic [spt_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import spt_pkg::*;
    `include "sorted_priority_table_assert.svh"

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PB = PRIORITY_BITS;
    localparam logic [PB-1:0] PMAX = '1;
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOC  = 4'b0010,
        ST_UPD  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [PB-1:0]         r_preq;
    logic [LEVEL_BITS-1:0] r_level;
    logic                  r_tp;
    logic [PB-1:0]         r_np;
    logic [CW-1:0]         r_count;
    logic                  r_aimed_v, r_preset_v;
    logic [KEY_BITS-1:0]   r_aimed, r_preset;
    logic [LEVEL_BITS-1:0] r_own;
    logic                  r_ok, r_ended;
    logic [PB-1:0]         r_kp;
    logic                  r_ovalid;

    t_cell_ctrl            ctrl;
    logic                  any, ok;
    logic [PB-1:0]         kp;
    logic [LEVEL_BITS-1:0] absdiff;

    logic [KEY_BITS-1:0] c_key   [TABLE_DEPTH];
    logic [PB-1:0]       c_prio  [TABLE_DEPTH];
    logic                c_match [TABLE_DEPTH];
    logic                c_pb    [TABLE_DEPTH];
    logic                c_after [TABLE_DEPTH];
    logic [PB-1:0]       c_acc   [TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0] pk, nk;
            logic [PB-1:0]       pp, np_, ac;
            logic                ppb, npb, af;
            if (g == 0) begin : g_first
                assign pk  = '0;
                assign pp  = '0;
                assign ppb = 1'b1;
            end else begin : g_mid
                assign pk  = c_key[g-1];
                assign pp  = c_prio[g-1];
                assign ppb = c_pb[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign nk  = '0;
                assign np_ = '0;
                assign npb = 1'b0;
                assign af  = 1'b0;
                assign ac  = '0;
            end else begin : g_inner
                assign nk  = c_key[g+1];
                assign np_ = c_prio[g+1];
                assign npb = c_pb[g+1];
                assign af  = c_after[g+1];
                assign ac  = c_acc[g+1];
            end
            spt_cell #(.PRIO_BITS(PB)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (ctrl),
                .i_new_prio  (r_np),
                .i_occ       (r_count > CW'(g)),
                .i_prev_key  (pk),
                .i_prev_prio (pp),
                .i_prev_pb   (ppb),
                .i_next_key  (nk),
                .i_next_prio (np_),
                .i_next_pb   (npb),
                .i_after     (af),
                .i_acc       (ac),
                .o_key       (c_key[g]),
                .o_prio      (c_prio[g]),
                .o_match     (c_match[g]),
                .o_pb        (c_pb[g]),
                .o_after     (c_after[g]),
                .o_acc       (c_acc[g])
            );
        end
    endgenerate

    assign any     = c_after[0];
    assign absdiff = (r_level > r_own) ? (r_level - r_own) : (r_own - r_level);

    always_comb begin
        ok = 1'b0;
        kp = any ? c_acc[0] : '0;
        case (r_op)
            OP_ADD: begin
                ok = !any && (r_count < FULL);
                if (ok) kp = r_np;
            end
            OP_REMOVE: begin
                ok = any;
                kp = '0;
            end
            OP_SET_PRIO: begin
                ok = any;
                if (ok) kp = r_np;
            end
            OP_TO_TOP: begin
                ok = any && !c_match[0];
                if (ok) kp = r_np;
            end
            OP_PRESET, OP_AIMED: ok = 1'b1;
            OP_CLEAR: begin
                ok = 1'b1;
                kp = '0;
            end
            default: ok = 1'b0;
        endcase
    end

    always_comb begin
        ctrl.loc  = (r_state == ST_LOC);
        ctrl.any  = any;
        ctrl.key  = r_key;
        ctrl.mode = MODE_HOLD;
        if (r_state == ST_UPD && ok) begin
            case (r_op)
                OP_REMOVE:                     ctrl.mode = MODE_REMOVE;
                OP_ADD, OP_SET_PRIO, OP_TO_TOP: ctrl.mode = MODE_INSERT;
                default:                       ctrl.mode = MODE_HOLD;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_LOC;
            ST_LOC:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_OUT;
            ST_OUT:  if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_aimed_v  <= 1'b0;
            r_aimed    <= '0;
            r_preset_v <= 1'b0;
            r_preset   <= '0;
            r_own      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == 1'b0) begin
                r_own <= pwdata[LEVEL_BITS-1:0];
            end
            if (r_state == ST_UPD && ok) begin
                case (r_op)
                    OP_ADD:    r_count <= r_count + ONE;
                    OP_REMOVE: begin
                        r_count <= r_count - ONE;
                        if (r_aimed_v && r_aimed == r_key) begin
                            r_aimed_v <= 1'b0;
                            r_aimed   <= '0;
                        end
                        if (r_preset_v && r_preset == r_key) begin
                            r_preset_v <= 1'b0;
                            r_preset   <= '0;
                        end
                    end
                    OP_PRESET: begin
                        r_preset_v <= r_tp;
                        r_preset   <= r_tp ? r_key : '0;
                    end
                    OP_AIMED: begin
                        r_aimed_v <= r_tp;
                        r_aimed   <= r_tp ? r_key : '0;
                    end
                    OP_CLEAR: begin
                        r_count    <= '0;
                        r_aimed_v  <= 1'b0;
                        r_aimed    <= '0;
                        r_preset_v <= 1'b0;
                        r_preset   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_OUT && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= t_op'(i_in.operation);
            r_key   <= i_in.key;
            r_preq  <= PB'(i_in.priority_req);
            r_level <= i_in.level;
            r_tp    <= i_in.target_present;
        end
        if (r_state == ST_LOC) begin
            case (r_op)
                OP_ADD:    r_np <= (r_preq != '0) ? r_preq : PB'(absdiff);
                OP_TO_TOP: r_np <= (c_prio[0] == PMAX) ? PMAX : c_prio[0] + PB'(1);
                default:   r_np <= r_preq;
            endcase
        end
        if (r_state == ST_UPD) begin
            r_ok    <= ok;
            r_ended <= ok && (r_op == OP_REMOVE) && (r_count == ONE);
            r_kp    <= kp;
        end
        if (r_state == ST_OUT && (!r_ovalid || o_out.ready)) begin
            o_out.ok             <= r_ok;
            o_out.head_present   <= (r_count != '0);
            o_out.head_key       <= (r_count != '0) ? c_key[0] : '0;
            o_out.head_priority  <= (r_count != '0) ? REQ_BITS'(c_prio[0]) : '0;
            o_out.entry_count    <= COUNT_BITS'(r_count);
            o_out.key_priority   <= REQ_BITS'(r_kp);
            o_out.aimed_present  <= r_aimed_v;
            o_out.aimed_key      <= r_aimed;
            o_out.preset_present <= r_preset_v;
            o_out.preset_key     <= r_preset;
            o_out.fight_ended    <= r_ended;
        end
    end

    assign o_out.valid = r_ovalid;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == 1'b0) ? APB_DW'(r_own) : '0;

    `SPT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `SPT_ASSERT_IMP(a_ended_empty, i_clk, i_rst_n, o_out.valid && o_out.fight_ended,
        o_out.entry_count == '0 && !o_out.head_present)
    `SPT_ASSERT_NXT(a_upd_to_out, i_clk, i_rst_n, r_state == ST_UPD, r_state == ST_OUT)
    `SPT_ASSERT_IMP(a_add_room, i_clk, i_rst_n,
        r_state == ST_UPD && ok && r_op == OP_ADD, r_count < FULL)
endmodule
`default_nettype wire

>>> sv/spt_cell.sv
// one slot of the sorted table: key match, insert position and shift
// depends on spt_pkg
`default_nettype none
module spt_cell #(
    parameter int PRIO_BITS = spt_pkg::PRIO_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  spt_pkg::t_cell_ctrl          i_ctrl,
    input  logic [PRIO_BITS-1:0]         i_new_prio,
    input  logic                         i_occ,
    input  logic [spt_pkg::KEY_BITS-1:0] i_prev_key,
    input  logic [PRIO_BITS-1:0]         i_prev_prio,
    input  logic                         i_prev_pb,
    input  logic [spt_pkg::KEY_BITS-1:0] i_next_key,
    input  logic [PRIO_BITS-1:0]         i_next_prio,
    input  logic                         i_next_pb,
    input  logic                         i_after,
    input  logic [PRIO_BITS-1:0]         i_acc,
    output logic [spt_pkg::KEY_BITS-1:0] o_key,
    output logic [PRIO_BITS-1:0]         o_prio,
    output logic                         o_match,
    output logic                         o_pb,
    output logic                         o_after,
    output logic [PRIO_BITS-1:0]         o_acc
);
    import spt_pkg::*;

    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic                 r_m;
    logic                 stays_ahead, pb, region_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= 1'b0;
        end else if (i_ctrl.loc) begin
            r_m <= i_occ && (r_key == i_ctrl.key);
        end
        r_key  <= n_key;
        r_prio <= n_prio;
    end

    always_comb begin
        // entry stays ahead of the moved one: higher, or equal and older
        stays_ahead = i_occ && !r_m && ((r_prio > i_new_prio) ||
                      ((r_prio == i_new_prio) && (i_ctrl.any ? i_after : 1'b1)));
        // matched slot reports whether everything above it stays ahead
        pb       = r_m ? i_prev_pb : stays_ahead;
        region_a = !i_ctrl.any || i_after || (r_m && !pb);
        n_key    = r_key;
        n_prio   = r_prio;
        case (i_ctrl.mode)
            MODE_REMOVE: begin
                if (!i_after) begin
                    n_key  = i_next_key;
                    n_prio = i_next_prio;
                end
            end
            MODE_INSERT: begin
                if (region_a) begin
                    if (!pb && i_prev_pb) begin
                        n_key  = i_ctrl.key;
                        n_prio = i_new_prio;
                    end else if (!pb) begin
                        n_key  = i_prev_key;
                        n_prio = i_prev_prio;
                    end
                end else begin
                    if (i_next_pb) begin
                        n_key  = i_next_key;
                        n_prio = i_next_prio;
                    end else if (pb) begin
                        n_key  = i_ctrl.key;
                        n_prio = i_new_prio;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key   = r_key;
    assign o_prio  = r_prio;
    assign o_match = r_m;
    assign o_pb    = pb;
    assign o_after = r_m | i_after;
    assign o_acc   = i_acc | (r_m ? r_prio : '0);
endmodule
`default_nettype wire

>>> test/tb_sorted_priority_table.sv
// self-checking testbench for the sorted priority table
// depends on spt_pkg, spt_if and sorted_priority_table
`timescale 1ns / 100ps
`default_nettype none
module tb_sorted_priority_table;
    import spt_pkg::*;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 2000;
    localparam int IDLE_LIM  = 2000;
    localparam int LEVEL_ADDR = 0;

    typedef struct packed {
        t_op        op;
        logic [7:0] key;
        logic [15:0] preq;
        logic [7:0] level;
        logic       tp;
    } t_op_beat;

    typedef struct packed {
        logic        ok;
        logic        head_present;
        logic [7:0]  head_key;
        logic [15:0] head_priority;
        logic [4:0]  entry_count;
        logic [15:0] key_priority;
        logic        aimed_present;
        logic [7:0]  aimed_key;
        logic        preset_present;
        logic [7:0]  preset_key;
        logic        fight_ended;
    } t_table_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    spt_in_if  in_ch();
    spt_out_if out_ch();

    sorted_priority_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  tbl_key [DEPTH];
    logic [15:0] tbl_prio [DEPTH];
    int          tbl_used;
    logic        aim_v, pre_v;
    logic [7:0]  aim_k, pre_k;
    logic [7:0]  own_lvl;

    t_op_beat    pending_ops[$];
    t_table_view expected_views[$];
    int          n_errors = 0;
    bit          hold_off = 1'b0;
    bit          stall_armed = 1'b0;
    bit          stall_done = 1'b0;

    function automatic int find_key(logic [7:0] k);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_key[i] == k) return i;
        return -1;
    endfunction

    // stable descending sort
    function automatic void resort();
        logic [7:0] k;
        logic [15:0] p;
        int j;
        for (int i = 1; i < tbl_used; i++) begin
            k = tbl_key[i];
            p = tbl_prio[i];
            j = i;
            while (j > 0 && tbl_prio[j-1] < p) begin
                tbl_key[j] = tbl_key[j-1];
                tbl_prio[j] = tbl_prio[j-1];
                j--;
            end
            tbl_key[j] = k;
            tbl_prio[j] = p;
        end
    endfunction

    function automatic t_table_view apply_op(t_op_beat b);
        t_table_view v;
        int idx;
        logic [15:0] mx;
        logic ok, ended;
        ok = 1'b0;
        ended = 1'b0;
        idx = find_key(b.key);
        case (b.op)
            OP_ADD: if (idx < 0 && tbl_used < DEPTH) begin
                tbl_key[tbl_used] = b.key;
                if (b.preq != 0) tbl_prio[tbl_used] = b.preq;
                else tbl_prio[tbl_used] = (b.level > own_lvl) ? 16'(b.level - own_lvl)
                                                              : 16'(own_lvl - b.level);
                tbl_used++;
                resort();
                ok = 1'b1;
            end
            OP_REMOVE: if (idx >= 0) begin
                for (int i = idx; i + 1 < tbl_used; i++) begin
                    tbl_key[i] = tbl_key[i+1];
                    tbl_prio[i] = tbl_prio[i+1];
                end
                tbl_used--;
                if (aim_v && aim_k == b.key) begin aim_v = 0; aim_k = 0; end
                if (pre_v && pre_k == b.key) begin pre_v = 0; pre_k = 0; end
                ended = (tbl_used == 0);
                ok = 1'b1;
            end
            OP_SET_PRIO: if (idx >= 0) begin
                tbl_prio[idx] = b.preq;
                resort();
                ok = 1'b1;
            end
            OP_TO_TOP: if (idx > 0) begin
                mx = 0;
                for (int i = 0; i < tbl_used; i++)
                    if (tbl_prio[i] > mx) mx = tbl_prio[i];
                tbl_prio[idx] = (mx == 16'hffff) ? mx : mx + 16'd1;
                resort();
                ok = 1'b1;
            end
            OP_PRESET: begin
                pre_v = b.tp;
                pre_k = b.tp ? b.key : 8'd0;
                ok = 1'b1;
            end
            OP_AIMED: begin
                aim_v = b.tp;
                aim_k = b.tp ? b.key : 8'd0;
                ok = 1'b1;
            end
            OP_CLEAR: begin
                tbl_used = 0;
                aim_v = 0; aim_k = 0; pre_v = 0; pre_k = 0;
                ok = 1'b1;
            end
            default: ;
        endcase
        idx = find_key(b.key);
        v.ok = ok;
        v.head_present = (tbl_used != 0);
        v.head_key = tbl_used ? tbl_key[0] : 8'd0;
        v.head_priority = tbl_used ? tbl_prio[0] : 16'd0;
        v.entry_count = 5'(tbl_used);
        v.key_priority = (idx >= 0) ? tbl_prio[idx] : 16'd0;
        v.aimed_present = aim_v;
        v.aimed_key = aim_k;
        v.preset_present = pre_v;
        v.preset_key = pre_k;
        v.fight_ended = ended;
        return v;
    endfunction

    task automatic report(string what, t_table_view got, t_table_view want);
        n_errors++;
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    // driver: a drawn gap of idle cycles after each beat, before the next one
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            t_op_beat b;
            if (in_ch.valid) begin
                b = t_op_beat'({t_op'(in_ch.operation), in_ch.key, in_ch.priority_req,
                    in_ch.level, in_ch.target_present});
                expected_views = {expected_views, apply_op(b)};
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                b = pending_ops.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.operation <= b.op;
                in_ch.key <= b.key;
                in_ch.priority_req <= b.preq;
                in_ch.level <= b.level;
                in_ch.target_present <= b.tp;
                send_gap <= $urandom_range(0, 5);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: a drawn gap of stalled cycles after each beat
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_table_view got;
                got = {out_ch.ok, out_ch.head_present, out_ch.head_key, out_ch.head_priority,
                       out_ch.entry_count, out_ch.key_priority, out_ch.aimed_present,
                       out_ch.aimed_key, out_ch.preset_present, out_ch.preset_key,
                       out_ch.fight_ended};
                if (expected_views.size() == 0) report("unexpected beat", got, '0);
                else begin
                    t_table_view want;
                    want = expected_views.pop_front();
                    if (got !== want) report("result", got, want);
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (out_ch.valid && out_ch.ready) begin
                int w;
                w = $urandom_range(0, 5);
                recv_gap <= w;
                out_ch.ready <= (w == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ch.ready <= (recv_gap == 1);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, counted here once the stimulus arms it
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (hold_off) begin
            hold_cnt <= hold_cnt - 1;
            if (hold_cnt == 1) begin
                hold_off <= 1'b0;
                stall_done <= 1'b1;
            end
        end else if (stall_armed && !stall_done) begin
            hold_off <= 1'b1;
            hold_cnt <= 200;
        end
    end

    // watchdog
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_LIM) begin
            $display("tb_sorted_priority_table NOT OK");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.key = '0;
        in_ch.priority_req = '0;
        in_ch.level = '0;
        in_ch.target_present = 1'b0;
        out_ch.ready = 1'b0;
    end

    task automatic apb_write(logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= APB_AW'(LEVEL_ADDR); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        own_lvl = val[7:0];
    endtask

    task automatic queue_op(t_op op, logic [7:0] k, logic [15:0] p, logic [7:0] l, logic t);
        t_op_beat b;
        b = '{op, k, p, l, t};
        pending_ops = {pending_ops, b};
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || in_ch.valid || expected_views.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // keys mostly from the given pool so that hits are common
    task automatic queue_random(int n, int pool);
        t_op op;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) op = OP_ADD;
            else if (r < 55) op = OP_REMOVE;
            else if (r < 68) op = OP_SET_PRIO;
            else if (r < 80) op = OP_TO_TOP;
            else if (r < 87) op = OP_PRESET;
            else if (r < 94) op = OP_AIMED;
            else if (r < 97) op = OP_CLEAR;
            else op = OP_UNUSED;
            queue_op(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, pool)),
                     ($urandom_range(0, 3) == 0) ? 16'd0 :
                     ($urandom_range(0, 5) == 0) ? 16'($urandom_range(65530, 65535)) :
                     16'($urandom),
                     8'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        tbl_used = 0; aim_v = 0; aim_k = 0; pre_v = 0; pre_k = 0; own_lvl = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: level-derived priority, ties, full table, saturation, targets
        queue_op(OP_ADD, 8'd0, 16'd0, 8'd255, 1'b0);
        queue_op(OP_ADD, 8'd255, 16'd255, 8'd0, 1'b0);
        queue_op(OP_ADD, 8'd255, 16'd5, 8'd0, 1'b0);
        queue_op(OP_ADD, 8'd7, 16'hffff, 8'd0, 1'b0);
        queue_op(OP_TO_TOP, 8'd7, 16'd0, 8'd0, 1'b0);
        queue_op(OP_TO_TOP, 8'd0, 16'd0, 8'd0, 1'b0);
        queue_op(OP_TO_TOP, 8'd99, 16'd0, 8'd0, 1'b0);
        queue_op(OP_SET_PRIO, 8'd255, 16'd0, 8'd0, 1'b0);
        queue_op(OP_SET_PRIO, 8'd98, 16'd3, 8'd0, 1'b0);
        queue_op(OP_PRESET, 8'd255, 16'd0, 8'd0, 1'b1);
        queue_op(OP_AIMED, 8'd0, 16'd0, 8'd0, 1'b1);
        queue_op(OP_REMOVE, 8'd255, 16'd0, 8'd0, 1'b0);
        queue_op(OP_REMOVE, 8'd255, 16'd0, 8'd0, 1'b0);
        queue_op(OP_UNUSED, 8'd7, 16'd1, 8'd1, 1'b1);
        for (int i = 1; i <= 15; i++) queue_op(OP_ADD, 8'(i + 20), 16'd100, 8'd0, 1'b0);
        queue_op(OP_ADD, 8'd200, 16'd1, 8'd0, 1'b0);
        queue_op(OP_CLEAR, 8'd0, 16'd0, 8'd0, 1'b0);
        queue_op(OP_ADD, 8'd1, 16'd9, 8'd0, 1'b0);
        queue_op(OP_REMOVE, 8'd1, 16'd0, 8'd0, 1'b0);
        queue_op(OP_AIMED, 8'd4, 16'd0, 8'd0, 1'b0);
        drain();

        apb_write(32'd255);
        queue_random(300, 24);
        drain();

        apb_write(32'd128);
        queue_random(200, 24);
        // long receiver stall while the sender keeps offering
        wait (pending_ops.size() < 150);
        stall_armed = 1'b1;
        wait (stall_done);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            apb_write(32'($urandom));
            queue_random(500, ph == 2 ? 255 : 20);
            drain();
        end
        apb_write(32'd0);
        queue_random(100, 20);
        drain();

        if (n_errors == 0 && expected_views.size() == 0)
            $display("tb_sorted_priority_table OK");
        else
            $display("tb_sorted_priority_table NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/spt_pkg.sv
sv/spt_if.sv
sv/spt_cell.sv
sv/sorted_priority_table.sv
test/tb_sorted_priority_table.sv
